// File: rtl/core/kmrd_pkg.sv
package kmrd_pkg;

  localparam int unsigned TYPE_W = 2;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned BITS_W = 18;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned DEB_W  = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef enum logic [TYPE_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_SCAN   = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic KIND_COMMIT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic sample_en;
    logic commit;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic token;
    logic ready;
    logic any_ready;
  } cell_stat_t;

endpackage

// File: rtl/core/kmrd_cell.sv
module kmrd_cell #(
  parameter int unsigned COL_W = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmrd_pkg::cell_ctl_t           ctl_i,
  input  logic                          tok_i,
  input  logic                          any_after_i,
  input  logic [COL_W-1:0]              cols_i,
  input  logic [kmrd_pkg::TIME_W-1:0]   now_i,
  input  logic [kmrd_pkg::DEB_W-1:0]    deb_i,
  output kmrd_pkg::cell_stat_t          stat_o,
  output logic [COL_W-1:0]              stable_o,
  output logic [COL_W-1:0]              pending_o
);

  logic [COL_W-1:0]            stable_q, stable_d;
  logic [COL_W-1:0]            pending_q, pending_d;
  logic [kmrd_pkg::TIME_W-1:0] stamp_q, stamp_d;
  logic                        bouncing_q, bouncing_d;
  logic                        token_q, token_d;
  logic [kmrd_pkg::TIME_W-1:0] elapsed;
  logic                        ready;

  assign elapsed = now_i - stamp_q;
  assign ready   = bouncing_q && (elapsed > kmrd_pkg::TIME_W'(deb_i));

  always_comb begin
    stable_d   = stable_q;
    pending_d  = pending_q;
    stamp_d    = stamp_q;
    bouncing_d = bouncing_q;
    token_d    = ctl_i.shift ? tok_i : token_q;
    if (ctl_i.sample_en && (pending_q != cols_i)) begin
      pending_d  = cols_i;
      stamp_d    = now_i;
      bouncing_d = 1'b1;
    end
    if (ctl_i.commit) begin
      stable_d   = pending_q;
      bouncing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= '0;
      pending_q  <= '0;
      stamp_q    <= '0;
      bouncing_q <= 1'b0;
      token_q    <= 1'b0;
    end else begin
      stable_q   <= stable_d;
      pending_q  <= pending_d;
      stamp_q    <= stamp_d;
      bouncing_q <= bouncing_d;
      token_q    <= token_d;
    end
  end

  assign stat_o.token     = token_q;
  assign stat_o.ready     = ready;
  assign stat_o.any_ready = ready | any_after_i;
  assign stable_o         = stable_q;
  assign pending_o        = pending_q;

endmodule

// File: rtl/core/key_matrix_row_debouncer_top.sv
// Per-row key matrix debouncer.
// Input channel (in_valid_i / in_stall_o) takes one request at a time:
//   row sample  - updates the row's pending value and stamp when the value changes, no result;
//   end of scan - a token walks the row cells in order, one cell per cycle
//                 unless an output stall holds it; each settled row commits,
//                 sends one result, the last of the pass with last_o set;
//   query       - one result: stable row ORed with other_half_bits_i.
// Output channel (out_valid_o / out_stall_i) is a single output register.
// A sample or query is taken into the request registers and then acted on;
// a query also waits for a free output register. An end of scan passes the
// token through every row cell. The next request is taken only once the
// current one finishes, so requests do not overlap.
// A stall on the output holds the token at a settling row until the output
// register frees; rows that do not commit are passed without waiting.
// Reset clears all rows, the token and the output; the debounce setting
// returns to 5 ms. Write cfg_we_i / cfg_wdata_i only while idle.
module key_matrix_row_debouncer_top #(
  parameter int unsigned ROWS    = 6,
  parameter int unsigned COLUMNS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kmrd_pkg::DEB_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kmrd_pkg::TYPE_W-1:0]   req_type_i,
  input  logic [kmrd_pkg::ROW_W-1:0]    row_index_i,
  input  logic [kmrd_pkg::BITS_W-1:0]   column_bits_i,
  input  logic [kmrd_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [kmrd_pkg::BITS_W-1:0]   other_half_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [kmrd_pkg::ROW_W-1:0]    out_row_o,
  output logic [kmrd_pkg::BITS_W-1:0]   out_bits_o,
  output logic                          last_o
);

  localparam int unsigned ColW = (COLUMNS < kmrd_pkg::BITS_W) ? COLUMNS : kmrd_pkg::BITS_W;

  logic [kmrd_pkg::DEB_W-1:0]  debounce_q;
  logic                        busy_q, busy_d;
  kmrd_pkg::req_e              type_q;
  logic [kmrd_pkg::ROW_W-1:0]  row_q;
  logic [ColW-1:0]             cols_q;
  logic [kmrd_pkg::TIME_W-1:0] now_q;
  logic [kmrd_pkg::BITS_W-1:0] other_q;

  logic                        out_valid_q, out_valid_d;
  logic                        kind_q;
  logic [kmrd_pkg::ROW_W-1:0]  orow_q;
  logic [kmrd_pkg::BITS_W-1:0] obits_q;
  logic                        last_q;

  kmrd_pkg::cell_ctl_t  ctl   [ROWS];
  kmrd_pkg::cell_stat_t stat  [ROWS];
  logic [ColW-1:0]      stable_w  [ROWS];
  logic [ColW-1:0]      pending_w [ROWS];
  logic [ROWS:0]        tok_chain;
  logic [ROWS:0]        any_chain;
  logic [ROWS-1:0]      token_v, commit_v;

  logic                        in_fire, slot_free, shift, holder_move, out_load;
  logic                        hold_ready, hold_last;
  logic [kmrd_pkg::ROW_W-1:0]  hold_row;
  logic [ColW-1:0]             hold_bits, query_stable;
  logic                        load_kind, load_last;
  logic [kmrd_pkg::ROW_W-1:0]  load_row;
  logic [kmrd_pkg::BITS_W-1:0] load_bits;

  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign tok_chain[0]    = in_fire && (kmrd_pkg::req_e'(req_type_i) == kmrd_pkg::REQ_SCAN);
  assign any_chain[ROWS] = 1'b0;

  always_comb begin
    hold_ready   = 1'b0;
    hold_last    = 1'b0;
    hold_row     = '0;
    hold_bits    = '0;
    query_stable = '0;
    for (int k = 0; k < ROWS; k++) begin
      if (token_v[k]) begin
        hold_ready = stat[k].ready;
        hold_last  = !any_chain[k+1];
        hold_row   = kmrd_pkg::ROW_W'(k);
        hold_bits  = pending_w[k];
      end
      if (32'(row_q) == k) begin
        query_stable = stable_w[k];
      end
    end
  end

  assign holder_move = busy_q && (type_q == kmrd_pkg::REQ_SCAN) && (|token_v)
                       && (!hold_ready || slot_free);
  assign shift       = in_fire || holder_move;

  for (genvar k = 0; k < ROWS; k++) begin : g_cell
    assign token_v[k]      = stat[k].token;
    assign commit_v[k]     = token_v[k] && stat[k].ready && holder_move;
    assign ctl[k].sample_en = busy_q && (type_q == kmrd_pkg::REQ_SAMPLE) && (32'(row_q) == k);
    assign ctl[k].commit    = commit_v[k];
    assign ctl[k].shift     = shift;
    assign tok_chain[k+1]   = stat[k].token;
    assign any_chain[k]     = stat[k].any_ready;

    kmrd_cell #(
      .COL_W (ColW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[k]),
      .tok_i       (tok_chain[k]),
      .any_after_i (any_chain[k+1]),
      .cols_i      (cols_q),
      .now_i       (now_q),
      .deb_i       (debounce_q),
      .stat_o      (stat[k]),
      .stable_o    (stable_w[k]),
      .pending_o   (pending_w[k])
    );
  end

  always_comb begin
    busy_d    = busy_q;
    out_load  = 1'b0;
    load_kind = kmrd_pkg::KIND_COMMIT;
    load_row  = hold_row;
    load_bits = kmrd_pkg::BITS_W'(hold_bits);
    load_last = hold_last;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (type_q)
        kmrd_pkg::REQ_SAMPLE: busy_d = 1'b0;
        kmrd_pkg::REQ_NONE:   busy_d = 1'b0;
        kmrd_pkg::REQ_QUERY: begin
          if (slot_free) begin
            busy_d    = 1'b0;
            out_load  = 1'b1;
            load_kind = kmrd_pkg::KIND_QUERY;
            load_row  = row_q;
            load_bits = kmrd_pkg::BITS_W'(query_stable) | other_q;
            load_last = 1'b1;
          end
        end
        kmrd_pkg::REQ_SCAN: begin
          out_load = holder_move && hold_ready;
          if (holder_move && token_v[ROWS-1]) begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= kmrd_pkg::DEBOUNCE_RESET;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type_q  <= kmrd_pkg::req_e'(req_type_i);
      row_q   <= row_index_i;
      cols_q  <= column_bits_i[ColW-1:0];
      now_q   <= now_ms_i;
      other_q <= other_half_bits_i;
    end
    if (out_load) begin
      kind_q  <= load_kind;
      orow_q  <= load_row;
      obits_q <= load_bits;
      last_q  <= load_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign out_row_o     = orow_q;
  assign out_bits_o    = obits_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token_v))
    else $error("more than one row cell holds the scan token");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|token_v) |-> (busy_q && (type_q == kmrd_pkg::REQ_SCAN)))
    else $error("scan token present outside an end-of-scan request");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(commit_v))
    else $error("more than one row committed in a cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int ROWS    = 6;
  localparam int COLUMNS = 18;
  localparam logic [kmrd_pkg::BITS_W-1:0] COL_MASK =
    kmrd_pkg::BITS_W'((64'd1 << COLUMNS) - 1);

  typedef struct packed {
    logic                        kind;
    logic [kmrd_pkg::ROW_W-1:0]  row;
    logic [kmrd_pkg::BITS_W-1:0] bits;
    logic                        last;
  } row_report_t;

  class debounce_predictor;
    logic [kmrd_pkg::DEB_W-1:0]  deb;
    logic [kmrd_pkg::BITS_W-1:0] stable[ROWS];
    logic [kmrd_pkg::BITS_W-1:0] pending[ROWS];
    logic [kmrd_pkg::TIME_W-1:0] stamp[ROWS];
    bit                          bouncing[ROWS];
    row_report_t                 due[$];
    int unsigned                 errors;
    int unsigned                 commits;
    int unsigned                 answers;

    function new();
      deb = kmrd_pkg::DEBOUNCE_RESET;
      for (int k = 0; k < ROWS; k++) begin
        stable[k]   = '0;
        pending[k]  = '0;
        stamp[k]    = '0;
        bouncing[k] = 1'b0;
      end
    endfunction

    function void note_request(kmrd_pkg::req_e req, logic [kmrd_pkg::ROW_W-1:0] row,
                               logic [kmrd_pkg::BITS_W-1:0] cols,
                               logic [kmrd_pkg::TIME_W-1:0] now,
                               logic [kmrd_pkg::BITS_W-1:0] other);
      row_report_t                 rep;
      int                          first;
      logic [kmrd_pkg::TIME_W-1:0] elapsed;
      logic [kmrd_pkg::BITS_W-1:0] masked;
      first  = due.size();
      masked = cols & COL_MASK;
      case (req)
        kmrd_pkg::REQ_SAMPLE: begin
          if (row < ROWS && pending[row] != masked) begin
            pending[row]  = masked;
            stamp[row]    = now;
            bouncing[row] = 1'b1;
          end
        end
        kmrd_pkg::REQ_SCAN: begin
          for (int k = 0; k < ROWS; k++) begin
            if (bouncing[k]) begin
              elapsed = now - stamp[k];
              if (elapsed > deb) begin
                stable[k]   = pending[k];
                bouncing[k] = 1'b0;
                rep.kind    = kmrd_pkg::KIND_COMMIT;
                rep.row     = kmrd_pkg::ROW_W'(k);
                rep.bits    = stable[k];
                rep.last    = 1'b0;
                due.push_back(rep);
              end
            end
          end
          if (due.size() > first) due[due.size()-1].last = 1'b1;
        end
        kmrd_pkg::REQ_QUERY: begin
          rep.kind = kmrd_pkg::KIND_QUERY;
          rep.row  = row;
          rep.bits = ((row < ROWS) ? stable[row] : '0) | other;
          rep.last = 1'b1;
          due.push_back(rep);
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_report(logic kind, logic [kmrd_pkg::ROW_W-1:0] row,
                      logic [kmrd_pkg::BITS_W-1:0] bits, logic last);
      row_report_t want;
      if (due.size() == 0) begin
        flag_mismatch("unrequested result row", 32'(row), 32'hFFFF_FFFF);
        return;
      end
      want = due.pop_front();
      if (kind !== want.kind) flag_mismatch("result_kind", 32'(kind), 32'(want.kind));
      if (row  !== want.row)  flag_mismatch("out_row", 32'(row), 32'(want.row));
      if (bits !== want.bits) flag_mismatch("out_bits", 32'(bits), 32'(want.bits));
      if (last !== want.last) flag_mismatch("last", 32'(last), 32'(want.last));
      if (want.kind == kmrd_pkg::KIND_COMMIT) commits++;
      else answers++;
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [kmrd_pkg::DEB_W-1:0]  cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [kmrd_pkg::TYPE_W-1:0] req_type_i = '0;
  logic [kmrd_pkg::ROW_W-1:0]  row_index_i = '0;
  logic [kmrd_pkg::BITS_W-1:0] column_bits_i = '0;
  logic [kmrd_pkg::TIME_W-1:0] now_ms_i = '0;
  logic [kmrd_pkg::BITS_W-1:0] other_half_bits_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        result_kind_o;
  logic [kmrd_pkg::ROW_W-1:0]  out_row_o;
  logic [kmrd_pkg::BITS_W-1:0] out_bits_o;
  logic                        last_o;

  debounce_predictor sb;
  bit                calm = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       n_requests = 0;
  int unsigned       n_settings = 1;

  key_matrix_row_debouncer_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .row_index_i       (row_index_i),
    .column_bits_i     (column_bits_i),
    .now_ms_i          (now_ms_i),
    .other_half_bits_i (other_half_bits_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .out_row_o         (out_row_o),
    .out_bits_o        (out_bits_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_report(result_kind_o, out_row_o, out_bits_o, last_o);
      stall_left = calm ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task send(kmrd_pkg::req_e req, logic [kmrd_pkg::ROW_W-1:0] row,
            logic [kmrd_pkg::BITS_W-1:0] cols, logic [kmrd_pkg::TIME_W-1:0] now,
            logic [kmrd_pkg::BITS_W-1:0] other);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    req_type_i        = req;
    row_index_i       = row;
    column_bits_i     = cols;
    now_ms_i          = now;
    other_half_bits_i = other;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, row, cols, now, other);
    n_requests++;
  endtask

  // hold requests until every result is out, then let a scan pass finish
  task settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.due.size() > 0) @(posedge clk_i);
    repeat (ROWS + 2) @(posedge clk_i);
  endtask

  task write_debounce(logic [kmrd_pkg::DEB_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.deb      = value;
    n_settings++;
  endtask

  initial begin
    logic [kmrd_pkg::DEB_W-1:0]  settings[6];
    logic [kmrd_pkg::BITS_W-1:0] last_cols[8];
    logic [kmrd_pkg::TIME_W-1:0] clock_ms;
    logic [kmrd_pkg::BITS_W-1:0] cols;
    logic [kmrd_pkg::ROW_W-1:0]  row;
    kmrd_pkg::req_e              req;
    int unsigned                 pick;
    int unsigned                 step;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send(kmrd_pkg::REQ_QUERY, 0, '0, 0, '0);
    send(kmrd_pkg::REQ_QUERY, 7, '1, 0, '1);
    send(kmrd_pkg::REQ_QUERY, 6, '0, 0, 18'h2AAAA);
    send(kmrd_pkg::REQ_SAMPLE, 0, '1, 100, '0);
    send(kmrd_pkg::REQ_SAMPLE, 5, 18'h15555, 100, '0);
    send(kmrd_pkg::REQ_SAMPLE, 6, '1, 100, '0);
    send(kmrd_pkg::REQ_SAMPLE, 7, '1, 100, '1);
    send(kmrd_pkg::REQ_NONE, 3, '1, 16'hFFFF, '1);
    send(kmrd_pkg::REQ_SCAN, 0, '0, 105, '0);
    send(kmrd_pkg::REQ_SCAN, 0, '0, 106, '0);
    send(kmrd_pkg::REQ_QUERY, 0, '0, 106, '0);
    send(kmrd_pkg::REQ_QUERY, 5, '0, 106, 18'h2AAAA);
    send(kmrd_pkg::REQ_SAMPLE, 2, 18'h1, 16'hFFFE, '0);
    send(kmrd_pkg::REQ_SCAN, 0, '0, 16'h0004, '0);
    send(kmrd_pkg::REQ_SAMPLE, 0, '1, 200, '0);
    send(kmrd_pkg::REQ_SCAN, 0, '0, 300, '0);
    for (int r = 0; r < ROWS; r++) begin
      send(kmrd_pkg::REQ_SAMPLE, kmrd_pkg::ROW_W'(r), 18'h7 << (3 * r), 400, '0);
    end
    send(kmrd_pkg::REQ_SCAN, 0, '0, 406, '0);

    settings = '{8'd0, 8'd255, 8'd1, kmrd_pkg::DEB_W'($urandom_range(2, 254)), 8'd128,
                 8'd5};
    foreach (last_cols[k]) last_cols[k] = '0;
    clock_ms = 16'd1000;
    foreach (settings[p]) begin
      write_debounce(settings[p]);
      step = settings[p] / 3 + 2;
      for (int i = 0; i < 76; i++) begin
        calm = (i % 40) < 8;
        if (i == 42) settle();
        if ($urandom_range(0, 29) == 0) clock_ms = kmrd_pkg::TIME_W'($urandom);
        else clock_ms = clock_ms + kmrd_pkg::TIME_W'($urandom_range(0, step));
        row = ($urandom_range(0, 9) == 0) ? kmrd_pkg::ROW_W'($urandom_range(6, 7))
                                          : kmrd_pkg::ROW_W'($urandom_range(0, ROWS - 1));
        case ($urandom_range(0, 3))
          0: cols = '0;
          1: cols = '1;
          2: cols = last_cols[row];
          default: cols = kmrd_pkg::BITS_W'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        req = (pick < 48) ? kmrd_pkg::REQ_SAMPLE : (pick < 68) ? kmrd_pkg::REQ_SCAN :
              (pick < 95) ? kmrd_pkg::REQ_QUERY : kmrd_pkg::REQ_NONE;
        send(req, row, cols, clock_ms, kmrd_pkg::BITS_W'($urandom));
        if (req == kmrd_pkg::REQ_SAMPLE) last_cols[row] = cols;
      end
    end
    calm = 1'b0;

    settle();
    $display("ran %0d requests over %0d debounce settings", n_requests, n_settings);
    $display("checked %0d row commits and %0d query answers", sb.commits, sb.answers);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
